@@ src/ssmb_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package ssmb_pkg;

  localparam int unsigned DIGITS = 3;

  localparam logic [2:0] REQ_SCAN  = 3'd0;
  localparam logic [2:0] REQ_INT   = 3'd1;
  localparam logic [2:0] REQ_CHAR  = 3'd2;
  localparam logic [2:0] REQ_POINT = 3'd3;
  localparam logic [2:0] REQ_BLANK = 3'd4;

  localparam logic [7:0] BLANK_CODE = 8'h20;
  localparam logic [7:0] POINT_BIT  = 8'h80;
  localparam logic [7:0] CODE_MASK  = 8'h7f;
  localparam logic [7:0] MINUS_CODE = 8'd16;
  localparam logic [7:0] H_CODE     = 8'd17;
  localparam logic [7:0] E_CODE     = 8'd14;
  localparam logic [7:0] GLYPHS     = 8'd18;

  typedef struct packed {
    logic take;
    logic scan;
    logic int_start;
    logic conv;
    logic fin;
    logic char_in;
    logic point;
    logic blank;
  } ssmb_cmd_t;

  typedef struct packed {
    logic [2:0] req;
    logic       int_short;
    logic       conv_last;
    logic       out_free;
  } ssmb_stat_t;

endpackage
`default_nettype wire

@@ src/seven_segment_mux_with_buttons.sv @@
// A scan request passes DISPATCH and SCAN, then is registered on the master side; it
// waits in SCAN while the output register is full. A new request is taken only in IDLE,
// after the last is done; an integer converts one decimal digit per cycle (divide by ten).
// The output register lets the next beat enter while a scan result waits.
// Reset (rst_ni low, asynchronous): display blank, scan index 0, buttons 0, no string.
`timescale 1ns / 1ps
`default_nettype none
module seven_segment_mux_with_buttons import ssmb_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // [15:0] number_value, [16] voltmeter_mode, [24:17] char_code,
  // [26:25] point_position, [34:27] button_lines, [39:35] zero
  input  wire logic [39:0] s_axis_tdata_i,
  input  wire logic        s_axis_tlast_i,   // last_char
  input  wire logic [2:0]  s_axis_tuser_i,   // [2:0] req_type
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // [1:0] anode_index, [9:2] segment_mask, [17:10] button_state, [23:18] zero
  output logic [23:0]      m_axis_tdata_o
);

  ssmb_cmd_t  cmd;
  ssmb_stat_t stat;
  logic [1:0] anode_index;
  logic [7:0] segment_mask;
  logic [7:0] button_state;

  ssmb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ssmb_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .req_type_i       (s_axis_tuser_i),
    .number_value_i   (s_axis_tdata_i[15:0]),
    .voltmeter_mode_i (s_axis_tdata_i[16]),
    .char_code_i      (s_axis_tdata_i[24:17]),
    .last_char_i      (s_axis_tlast_i),
    .point_position_i (s_axis_tdata_i[26:25]),
    .button_lines_i   (s_axis_tdata_i[34:27]),
    .out_valid_o      (m_axis_tvalid_o),
    .out_ready_i      (m_axis_tready_i),
    .anode_index_o    (anode_index),
    .segment_mask_o   (segment_mask),
    .button_state_o   (button_state)
  );

  assign m_axis_tdata_o = {6'h00, button_state, segment_mask, anode_index};

endmodule
`default_nettype wire

@@ src/ssmb_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
module ssmb_ctrl import ssmb_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire ssmb_stat_t stat_i,
  output ssmb_cmd_t       cmd_o
);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_DISPATCH = 3'd1;
  localparam logic [2:0] ST_SCAN     = 3'd2;
  localparam logic [2:0] ST_CONV     = 3'd3;
  localparam logic [2:0] ST_FIN      = 3'd4;

  logic [2:0] state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        state_d = ST_IDLE;
        unique case (stat_i.req)
          REQ_SCAN: state_d = ST_SCAN;
          REQ_INT: begin
            cmd_o.int_start = 1'b1;
            if (!stat_i.int_short) state_d = ST_CONV;
          end
          REQ_CHAR:  cmd_o.char_in = 1'b1;
          REQ_POINT: cmd_o.point   = 1'b1;
          REQ_BLANK: cmd_o.blank   = 1'b1;
          default: ;
        endcase
      end
      ST_SCAN: begin
        if (stat_i.out_free) begin
          cmd_o.scan = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      ST_CONV: begin
        cmd_o.conv = 1'b1;
        if (stat_i.conv_last) state_d = ST_FIN;
      end
      ST_FIN: begin
        cmd_o.fin = 1'b1;
        state_d   = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

@@ src/ssmb_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
module ssmb_dp import ssmb_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire ssmb_cmd_t         cmd_i,
  output ssmb_stat_t             stat_o,
  input  wire logic [2:0]        req_type_i,
  input  wire logic signed [15:0] number_value_i,
  input  wire logic              voltmeter_mode_i,
  input  wire logic [7:0]        char_code_i,
  input  wire logic              last_char_i,
  input  wire logic [1:0]        point_position_i,
  input  wire logic [7:0]        button_lines_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [1:0]             anode_index_o,
  output logic [7:0]             segment_mask_o,
  output logic [7:0]             button_state_o
);

  function automatic logic [7:0] glyph_seg(input logic [6:0] g);
    logic [7:0] s;
    unique case (g)
      7'd0:  s = 8'h3f;
      7'd1:  s = 8'h06;
      7'd2:  s = 8'h5b;
      7'd3:  s = 8'h4f;
      7'd4:  s = 8'h66;
      7'd5:  s = 8'h6d;
      7'd6:  s = 8'h7d;
      7'd7:  s = 8'h07;
      7'd8:  s = 8'h7f;
      7'd9:  s = 8'h6f;
      7'd10: s = 8'h77;
      7'd11: s = 8'h7c;
      7'd12: s = 8'h39;
      7'd13: s = 8'h5e;
      7'd14: s = 8'h79;
      7'd15: s = 8'h71;
      7'd16: s = 8'h40;
      7'd17: s = 8'h74;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

  // held item
  logic [2:0]         req_q;
  logic signed [15:0] num_q;
  logic               volt_q;
  logic [7:0]         ch_q;
  logic               last_q;
  logic [1:0]         pos_q;
  logic [7:0]         lines_q;

  logic [7:0] digit_q [DIGITS];
  logic [7:0] digit_d [DIGITS];
  logic [7:0] coll_q  [DIGITS];
  logic [7:0] coll_d  [DIGITS];
  logic [1:0] scan_q, scan_d;
  logic [7:0] btn_q, btn_d;
  logic [1:0] cnt_q, cnt_d;
  logic       active_q, active_d;

  logic [9:0] mag_q, mag_d;
  logic [1:0] n_q, n_d;
  logic       exh_q, exh_d;
  logic       neg_q, neg_d;

  logic       out_valid_q, out_valid_d;
  logic [1:0] out_idx_q;
  logic [7:0] out_seg_q;
  logic [7:0] out_btn_q;

  logic       out_range;
  logic       is_zero;
  logic [15:0] abs_num;
  logic [17:0] prod;
  logic [9:0]  quot;
  logic [3:0]  rem;
  logic [13:0] q10;

  logic [1:0] scan_idx;
  logic [7:0] scan_code;
  logic [7:0] scan_seg;

  logic       ch_valid;
  logic       ch_dot;
  logic [7:0] ch_code;
  logic [1:0] cnt_e;
  logic [7:0] coll_n [DIGITS];
  logic [1:0] cnt_n;
  logic [2:0] src_idx;

  assign out_range = (num_q < -16'sd99) || (num_q > 16'sd999);
  assign is_zero   = (num_q == 16'sd0);
  assign abs_num   = num_q[15] ? 16'(-num_q) : 16'(num_q);

  // divide by ten via reciprocal, exact below 1029
  assign prod = mag_q * 8'd205;
  assign quot = {3'b000, prod[17:11]};
  assign q10  = quot * 4'd10;
  assign rem  = 4'(mag_q - q10[9:0]);

  assign scan_idx  = (scan_q < 2'(DIGITS)) ? scan_q : 2'd0;
  assign scan_code = digit_q[scan_idx];
  always_comb begin
    scan_seg = ((scan_code & CODE_MASK) < GLYPHS) ? glyph_seg(scan_code[6:0]) : 8'h00;
    if (scan_code[7]) scan_seg = scan_seg | POINT_BIT;
  end

  always_comb begin
    ch_valid = 1'b1;
    ch_dot   = 1'b0;
    ch_code  = 8'h00;
    priority if (ch_q >= "0" && ch_q <= "9") begin
      ch_code = ch_q - 8'(48);
    end else if (ch_q >= "a" && ch_q <= "f") begin
      ch_code = ch_q - 8'(87);
    end else if (ch_q >= "A" && ch_q <= "F") begin
      ch_code = ch_q - 8'(55);
    end else if (ch_q == "-") begin
      ch_code = MINUS_CODE;
    end else if (ch_q == "h" || ch_q == "H") begin
      ch_code = H_CODE;
    end else if (ch_q == " ") begin
      ch_code = BLANK_CODE;
    end else if (ch_q == ".") begin
      ch_dot = 1'b1;
    end else begin
      ch_valid = 1'b0;
    end
  end

  always_comb begin
    cnt_e = active_q ? cnt_q : 2'd0;
    for (int i = 0; i < DIGITS; i++) coll_n[i] = coll_q[i];
    cnt_n = cnt_e;
    if (cnt_e < 2'(DIGITS) && ch_valid) begin
      if (ch_dot) begin
        if (cnt_e == 2'd0) begin
          coll_n[0] = 8'hff;
          cnt_n     = 2'd1;
        end else begin
          coll_n[cnt_e - 2'd1] = coll_q[cnt_e - 2'd1] | POINT_BIT;
        end
      end else begin
        coll_n[cnt_e] = ch_code;
        cnt_n         = cnt_e + 2'd1;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < DIGITS; i++) digit_d[i] = digit_q[i];
    for (int i = 0; i < DIGITS; i++) coll_d[i] = coll_q[i];
    scan_d      = scan_q;
    btn_d       = btn_q;
    cnt_d       = cnt_q;
    active_d    = active_q;
    mag_d       = mag_q;
    n_d         = n_q;
    exh_d       = exh_q;
    neg_d       = neg_q;
    out_valid_d = out_valid_q && !out_ready_i;
    src_idx     = 3'd0;

    if (cmd_i.scan) begin
      out_valid_d = 1'b1;
      if (scan_idx == 2'd1) btn_d = lines_q;
      scan_d = (scan_idx + 2'd1 >= 2'(DIGITS)) ? 2'd0 : scan_idx + 2'd1;
    end

    if (cmd_i.int_start) begin
      if (out_range) begin
        digit_d[0] = MINUS_CODE;
        digit_d[1] = MINUS_CODE;
        digit_d[2] = E_CODE;
        scan_d     = 2'd0;
      end else begin
        for (int i = 0; i < DIGITS; i++) digit_d[i] = volt_q ? 8'h00 : BLANK_CODE;
        if (is_zero) digit_d[DIGITS-1] = 8'h00;
        mag_d = abs_num[9:0];
        n_d   = 2'(DIGITS - 1);
        exh_d = 1'b0;
        neg_d = num_q[15];
      end
    end

    if (cmd_i.conv) begin
      digit_d[n_q] = {4'h0, rem};
      mag_d = quot;
      if (n_q == 2'd0) exh_d = 1'b1;
      else n_d = n_q - 2'd1;
    end

    if (cmd_i.fin) begin
      if (neg_q && !exh_q) digit_d[n_q] = MINUS_CODE;
      if (volt_q) digit_d[0] = ((neg_q && !exh_q && n_q == 2'd0) ? MINUS_CODE : digit_q[0])
                               | POINT_BIT;
    end

    if (cmd_i.char_in) begin
      if (last_q) begin
        for (int j = 0; j < DIGITS; j++) begin
          src_idx = {1'b0, cnt_n} + 3'(j);
          if (src_idx >= 3'(DIGITS)) digit_d[j] = coll_n[2'(src_idx - 3'(DIGITS))];
          else digit_d[j] = BLANK_CODE;
        end
        scan_d   = 2'd0;
        active_d = 1'b0;
        cnt_d    = cnt_n;
      end else begin
        active_d = 1'b1;
        cnt_d    = cnt_n;
      end
      for (int i = 0; i < DIGITS; i++) coll_d[i] = coll_n[i];
    end

    if (cmd_i.point) begin
      if (pos_q < 2'(DIGITS)) digit_d[pos_q] = digit_q[pos_q] | POINT_BIT;
    end

    if (cmd_i.blank) begin
      for (int i = 0; i < DIGITS; i++) digit_d[i] = BLANK_CODE;
      scan_d = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DIGITS; i++) digit_q[i] <= BLANK_CODE;
      scan_q      <= 2'd0;
      btn_q       <= 8'h00;
      cnt_q       <= 2'd0;
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      for (int i = 0; i < DIGITS; i++) digit_q[i] <= digit_d[i];
      scan_q      <= scan_d;
      btn_q       <= btn_d;
      cnt_q       <= cnt_d;
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      req_q   <= req_type_i;
      num_q   <= number_value_i;
      volt_q  <= voltmeter_mode_i;
      ch_q    <= char_code_i;
      last_q  <= last_char_i;
      pos_q   <= point_position_i;
      lines_q <= button_lines_i;
    end
    for (int i = 0; i < DIGITS; i++) coll_q[i] <= coll_d[i];
    mag_q <= mag_d;
    n_q   <= n_d;
    exh_q <= exh_d;
    neg_q <= neg_d;
    if (cmd_i.scan) begin
      out_idx_q <= scan_idx;
      out_seg_q <= scan_seg;
      out_btn_q <= btn_d;
    end
  end

  assign stat_o.req       = req_q;
  assign stat_o.int_short = out_range || is_zero;
  assign stat_o.conv_last = (n_q == 2'd0) || (quot == 10'd0);
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o    = out_valid_q;
  assign anode_index_o  = out_idx_q;
  assign segment_mask_o = out_seg_q;
  assign button_state_o = out_btn_q;

endmodule
`default_nettype wire

@@ test/ssmb_checker.sv @@
`timescale 1ns / 1ps
module ssmb_checker import ssmb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [39:0] s_tdata_i,
  input  logic        s_tlast_i,
  input  logic [2:0]  s_tuser_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [23:0] m_tdata_i,
  output int          mismatches_o,
  output int          pending_o
);

  typedef struct packed {
    logic [1:0] anode;
    logic [7:0] seg;
    logic [7:0] btn;
  } scan_beat_t;

  scan_beat_t scan_q[$];
  scan_beat_t want;

  logic [7:0] disp_codes [0:DIGITS-1];
  logic [7:0] str_codes [0:DIGITS-1];
  int         scan_pos;
  int         str_len;
  logic       str_open;
  logic [7:0] btn_latch;

  int n_bad = 0;
  int n_wait = 0;
  assign mismatches_o = n_bad;
  assign pending_o    = n_wait;

  task automatic report(input string what, input int got, input int exp_val);
    $display("%0t: %s mismatch, got %0h expected %0h", $time, what, got, exp_val);
    n_bad++;
  endtask

  // segments A..G in bits 0..6
  function automatic logic [7:0] glyph_lit(input logic [6:0] g);
    case (g)
      7'd0:    glyph_lit = 8'h3f;
      7'd1:    glyph_lit = 8'h06;
      7'd2:    glyph_lit = 8'h5b;
      7'd3:    glyph_lit = 8'h4f;
      7'd4:    glyph_lit = 8'h66;
      7'd5:    glyph_lit = 8'h6d;
      7'd6:    glyph_lit = 8'h7d;
      7'd7:    glyph_lit = 8'h07;
      7'd8:    glyph_lit = 8'h7f;
      7'd9:    glyph_lit = 8'h6f;
      7'd10:   glyph_lit = 8'h77;
      7'd11:   glyph_lit = 8'h7c;
      7'd12:   glyph_lit = 8'h39;
      7'd13:   glyph_lit = 8'h5e;
      7'd14:   glyph_lit = 8'h79;
      7'd15:   glyph_lit = 8'h71;
      7'd16:   glyph_lit = 8'h40;
      7'd17:   glyph_lit = 8'h74;
      default: glyph_lit = 8'h00;
    endcase
  endfunction

  task automatic fill_display(input logic [7:0] code);
    for (int k = 0; k < DIGITS; k++) disp_codes[k] = code;
  endtask

  task automatic take_scan(input logic [7:0] lines);
    logic [7:0] code;
    scan_beat_t beat;
    code = disp_codes[scan_pos];
    if (scan_pos == 1) btn_latch = lines;
    beat.anode = 2'(scan_pos);
    beat.seg   = glyph_lit(code[6:0]) | (code & POINT_BIT);
    beat.btn   = btn_latch;
    scan_q.push_back(beat);
    scan_pos = (scan_pos + 1 >= DIGITS) ? 0 : scan_pos + 1;
  endtask

  task automatic show_number(input int v, input logic volt);
    int  n;
    logic neg;
    n   = DIGITS - 1;
    neg = 1'b0;
    if (v < -99 || v > 999) begin
      disp_codes[0] = MINUS_CODE;
      disp_codes[1] = MINUS_CODE;
      disp_codes[2] = E_CODE;
      scan_pos = 0;
    end else begin
      fill_display(volt ? 8'h00 : BLANK_CODE);
      if (v == 0) begin
        disp_codes[DIGITS-1] = 8'h00;
      end else begin
        if (v < 0) begin
          neg = 1'b1;
          v = -v;
        end
        do begin
          disp_codes[n] = 8'(v % 10);
          v = v / 10;
          n--;
        end while (n >= 0 && v != 0);
        if (neg && n >= 0) disp_codes[n] = MINUS_CODE;
        if (volt) disp_codes[0] |= POINT_BIT;
      end
    end
  endtask

  task automatic collect_char(input logic [7:0] ch);
    logic [7:0] code;
    logic ok;
    ok = 1'b1;
    code = 8'h00;
    if (str_len < DIGITS) begin
      if (ch >= "0" && ch <= "9") code = ch - "0";
      else if (ch >= "a" && ch <= "f") code = ch - "a" + 8'd10;
      else if (ch >= "A" && ch <= "F") code = ch - "A" + 8'd10;
      else if (ch == "-") code = MINUS_CODE;
      else if (ch == "h" || ch == "H") code = H_CODE;
      else if (ch == " ") code = BLANK_CODE;
      else if (ch == ".") begin
        ok = 1'b0;
        // leading point gets its own blank position
        if (str_len == 0) begin
          str_codes[0] = 8'hff;
          str_len = 1;
        end else begin
          str_codes[str_len-1] |= POINT_BIT;
        end
      end else begin
        ok = 1'b0;
      end
      if (ok) begin
        str_codes[str_len] = code;
        str_len++;
      end
    end
  endtask

  task automatic commit_string();
    fill_display(BLANK_CODE);
    for (int k = 0; k < str_len && k < DIGITS; k++)
      disp_codes[DIGITS-1-k] = str_codes[str_len-1-k];
    scan_pos = 0;
    str_open = 1'b0;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_display(BLANK_CODE);
      scan_pos  = 0;
      str_len   = 0;
      str_open  = 1'b0;
      btn_latch = 8'h00;
      scan_q.delete();
      n_wait = 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        if (scan_q.size() == 0) begin
          report("unexpected beat", int'(m_tdata_i), 0);
        end else begin
          want = scan_q.pop_front();
          if (m_tdata_i[1:0] != want.anode)
            report("anode_index", int'(m_tdata_i[1:0]), int'(want.anode));
          if (m_tdata_i[9:2] != want.seg)
            report("segment_mask", int'(m_tdata_i[9:2]), int'(want.seg));
          if (m_tdata_i[17:10] != want.btn)
            report("button_state", int'(m_tdata_i[17:10]), int'(want.btn));
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        case (s_tuser_i)
          REQ_SCAN:  take_scan(s_tdata_i[34:27]);
          REQ_INT:   show_number(int'($signed(s_tdata_i[15:0])), s_tdata_i[16]);
          REQ_CHAR: begin
            if (!str_open) begin
              str_len  = 0;
              str_open = 1'b1;
            end
            collect_char(s_tdata_i[24:17]);
            if (s_tlast_i) commit_string();
          end
          REQ_POINT: begin
            if (s_tdata_i[26:25] < DIGITS) disp_codes[s_tdata_i[26:25]] |= POINT_BIT;
          end
          REQ_BLANK: begin
            fill_display(BLANK_CODE);
            scan_pos = 0;
          end
          default: ;
        endcase
      end
      n_wait = scan_q.size();
    end
  end

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
module tb;
  import ssmb_pkg::*;

  localparam logic [2:0] REQ_SPARE_LO = 3'd5;
  localparam logic [2:0] REQ_SPARE_HI = 3'd7;
  localparam int         N_ITEMS      = 1000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [39:0] s_data = '0;
  logic        s_last = 1'b0;
  logic [2:0]  s_user = REQ_SCAN;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [23:0] m_data;
  int          mismatches;
  int          pending;

  int burst_left = 0;
  int n_sent = 0;
  int rx_mode = 0;
  int rx_left = 0;

  seven_segment_mux_with_buttons dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tlast_i  (s_last),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  ssmb_checker chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_valid),
    .s_tready_i   (s_ready),
    .s_tdata_i    (s_data),
    .s_tlast_i    (s_last),
    .s_tuser_i    (s_user),
    .m_tvalid_i   (m_valid),
    .m_tready_i   (m_ready),
    .m_tdata_i    (m_data),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // receiver: stretches of always-ready, random, sparse and periodic stalls
  always @(posedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(8, 80);
    end
    rx_left--;
    case (rx_mode)
      0:       m_ready <= 1'b1;
      1:       m_ready <= 1'($urandom_range(0, 1));
      2:       m_ready <= ($urandom_range(0, 3) == 0);
      default: m_ready <= (rx_left % 16 == 0);
    endcase
  end

  task automatic send(input logic [2:0] req, input logic [15:0] num, input logic volt,
                      input logic [7:0] ch, input logic last, input logic [1:0] pos,
                      input logic [7:0] lines);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    s_valid <= 1'b1;
    s_data  <= {5'b0, lines, pos, ch, volt, num};
    s_last  <= last;
    s_user  <= req;
    do @(posedge clk_i); while (!s_ready);
    burst_left--;
    n_sent++;
  endtask

  task automatic send_rand(input logic [2:0] req);
    send(req, 16'($urandom), 1'($urandom), 8'($urandom), 1'($urandom), 2'($urandom),
         8'($urandom));
  endtask

  task automatic drain();
    s_valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (8) @(posedge clk_i);
    burst_left = 0;
  endtask

  function automatic logic [15:0] pick_number();
    case ($urandom_range(0, 9))
      0: pick_number = 16'($urandom);
      1: begin
        case ($urandom_range(0, 7))
          0: pick_number = 16'(-100);
          1: pick_number = 16'(-99);
          2: pick_number = 16'd999;
          3: pick_number = 16'd1000;
          4: pick_number = 16'd0;
          5: pick_number = 16'(-1);
          6: pick_number = 16'h8000;
          default: pick_number = 16'h7fff;
        endcase
      end
      2, 3: pick_number = 16'($urandom_range(0, 999));
      4:    pick_number = 16'(-$urandom_range(1, 99));
      5:    pick_number = 16'($urandom_range(0, 9));
      6:    pick_number = 16'($urandom_range(10, 99));
      default: pick_number = 16'($urandom_range(0, 1140) - 120);
    endcase
  endfunction

  function automatic logic [7:0] pick_char();
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4, 5: pick_char = "0" + 8'($urandom_range(0, 9));
      6, 7:             pick_char = "a" + 8'($urandom_range(0, 5));
      8, 9:             pick_char = "A" + 8'($urandom_range(0, 5));
      10:               pick_char = "-";
      11:               pick_char = "h";
      12:               pick_char = "H";
      13:               pick_char = " ";
      14, 15, 16:       pick_char = ".";
      default:          pick_char = 8'($urandom);
    endcase
  endfunction

  task automatic send_string();
    int  len;
    logic ends;
    len  = $urandom_range(1, 5);
    ends = ($urandom_range(0, 9) != 0);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 4) == 0) send_rand(REQ_SCAN);
      else if ($urandom_range(0, 19) == 0) send_rand(3'($urandom_range(REQ_POINT, REQ_BLANK)));
      send(REQ_CHAR, 16'($urandom), 1'($urandom), pick_char(), ends && (i == len - 1),
           2'($urandom), 8'($urandom));
    end
  endtask

  initial begin
    int  r;
    logic paused;
    paused = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send(REQ_INT, 16'h7fff, 1'b0, 8'h00, 1'b0, 2'd0, 8'h00);
    repeat (3) send_rand(REQ_SCAN);
    send(REQ_INT, 16'd0, 1'b1, 8'hff, 1'b1, 2'd3, 8'hff);
    send_rand(REQ_SCAN);
    send(REQ_INT, 16'(-99), 1'b1, 8'h00, 1'b0, 2'd0, 8'h00);
    send(REQ_POINT, 16'h0, 1'b0, 8'h00, 1'b0, 2'd3, 8'h00);
    send(REQ_POINT, 16'h0, 1'b0, 8'h00, 1'b0, 2'd1, 8'h00);
    repeat (3) send_rand(REQ_SCAN);
    send(REQ_CHAR, 16'h0, 1'b0, ".", 1'b0, 2'd0, 8'hff);
    send(REQ_CHAR, 16'h0, 1'b0, "H", 1'b0, 2'd0, 8'h00);
    send(REQ_BLANK, 16'h0, 1'b0, 8'h00, 1'b0, 2'd0, 8'h00);
    send(REQ_CHAR, 16'h0, 1'b0, "z", 1'b0, 2'd0, 8'h00);
    send(REQ_CHAR, 16'h0, 1'b0, "f", 1'b0, 2'd0, 8'h00);
    send(REQ_CHAR, 16'h0, 1'b0, "9", 1'b0, 2'd0, 8'h00);
    send(REQ_CHAR, 16'h0, 1'b0, "~", 1'b1, 2'd0, 8'h00);
    repeat (3) send_rand(REQ_SCAN);
    send_rand(REQ_SPARE_HI);
    send(REQ_INT, 16'h8000, 1'b1, 8'hff, 1'b1, 2'd3, 8'hff);
    send_rand(REQ_SPARE_LO);
    drain();

    while (n_sent < N_ITEMS) begin
      if (!paused && n_sent >= N_ITEMS / 2) begin
        drain();
        paused = 1'b1;
      end
      r = $urandom_range(0, 99);
      if (r < 45) send_rand(REQ_SCAN);
      else if (r < 58)
        send(REQ_INT, pick_number(), 1'($urandom), 8'($urandom), 1'($urandom), 2'($urandom),
             8'($urandom));
      else if (r < 75) send_string();
      else if (r < 83) send_rand(REQ_POINT);
      else if (r < 89) send_rand(REQ_BLANK);
      else if (r < 93) send_rand(3'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI)));
      else send_rand(3'($urandom));
    end

    drain();
    if (mismatches == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

@@ filelist.f @@
src/ssmb_pkg.sv
src/ssmb_ctrl.sv
src/ssmb_dp.sv
src/seven_segment_mux_with_buttons.sv
test/ssmb_checker.sv
test/tb.sv
